### sv/oriented_box_point_test_unit_defines.svh
// Assertion macros shared by the checker of the oriented box point test unit.
// Depends on nothing; included by the files that assert.
`ifndef ORIENTED_BOX_POINT_TEST_UNIT_DEFINES_SVH
`define ORIENTED_BOX_POINT_TEST_UNIT_DEFINES_SVH

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define OBTU_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("oriented box point test: implication check failed");

// The expression must never be true out of reset.
`define OBTU_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
    else $error("oriented box point test: forbidden condition seen");

`endif

### sv/obtu_pkg.sv
// Shared types, widths and the quarter-wave sine table of the oriented box point test.
// Depends on nothing; used by every design module of the block and by the testbench.
package obtu_pkg;

  // Number of table steps over a quarter turn.
  localparam int SINE_TABLE_ENTRIES = 1024;
  localparam int IDX_W = $clog2(SINE_TABLE_ENTRIES + 1);
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Field and datapath widths.
  localparam int COORD_W = 24;
  localparam int ANGLE_W = 16;
  localparam int CODE_W = 8;
  localparam int DIFF_W = COORD_W + 1;     // point minus origin
  localparam int TRIG_W = 18;              // signed -65536..65536
  localparam int PROD_W = DIFF_W + TRIG_W; // first products
  localparam int FWD_W = PROD_W + 1;       // lx and forward sums
  localparam int WIDE_W = FWD_W + TRIG_W;  // forward times pitch terms
  localparam int LOC_W = WIDE_W + 1;       // local y and z

  typedef logic [16:0] sine_t;
  typedef sine_t sine_rom_t [SINE_TABLE_ENTRIES + 1];

  // Payload that travels beside the trig lookup into the rotation pipeline.
  typedef struct packed {
    logic                      valid;
    logic signed [DIFF_W-1:0]  rx;
    logic signed [DIFF_W-1:0]  ry;
    logic signed [DIFF_W-1:0]  rz;
    logic [CODE_W-1:0]         hx;
    logic [CODE_W-1:0]         hy;
    logic [CODE_W-1:0]         hz;
  } rot_in_t;

  // Signed sine and cosine of both negated angles.
  typedef struct packed {
    logic signed [TRIG_W-1:0] s;
    logic signed [TRIG_W-1:0] c;
    logic signed [TRIG_W-1:0] sp;
    logic signed [TRIG_W-1:0] cp;
  } trig_t;

  // Builds the table at elaboration: Taylor series in Q.30, rounded to Q.16.
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    logic [63:0] t;
    logic [63:0] term;
    longint sum;
    for (int i = 0; i <= SINE_TABLE_ENTRIES; i++) begin
      t = (64'(i) * HALF_PI_Q30) / 64'(SINE_TABLE_ENTRIES);
      term = t;
      sum = longint'(t);
      for (int k = 1; k <= 7; k++) begin
        term = (term * t) >> 30;
        term = ((term * t) >> 30) / 64'((2 * k) * (2 * k + 1));
        if ((k % 2) == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      sum = (sum + 8192) / 16384;
      if (sum > 65536) begin
        sum = 65536;
      end
      rom[i] = 17'(sum);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

### sv/oriented_box_point_test_unit.sv
// Top level of the oriented box point test: input stages and the pipeline wiring.
// Depends on obtu_pkg, obtu_sincos and obtu_rotate.
//
// Usage:
//   A query is transferred at a rising clock edge with start_i high and busy_o low.
//   busy_o is held low: the pipeline takes a new query in every cycle, so the
//   sustained throughput is one query per clock.
//   Each query gives point, box centre, yaw and pitch angles and three half-size
//   codes; its answer appears on inside_res_o, marked by done_o, for exactly one
//   cycle. Results are transferred in the order of the queries.
//   The pipeline holds two stages for the sine table lookup (address register,
//   then registered table read), then the yaw products, the yaw sums, the pitch
//   products, the pitch sums and the output register holding the limit compare.
//   The receiver cannot stall the block: every result is shown once.
//   Reset clears all valid bits at once, so no result comes out of a query
//   that was in flight when reset was asserted; the table needs no fill.
module oriented_box_point_test_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic signed [obtu_pkg::COORD_W-1:0] point_x_i,
  input  logic signed [obtu_pkg::COORD_W-1:0] point_y_i,
  input  logic signed [obtu_pkg::COORD_W-1:0] point_z_i,
  input  logic signed [obtu_pkg::COORD_W-1:0] origin_x_i,
  input  logic signed [obtu_pkg::COORD_W-1:0] origin_y_i,
  input  logic signed [obtu_pkg::COORD_W-1:0] origin_z_i,
  input  logic [obtu_pkg::ANGLE_W-1:0]        yaw_angle_i,
  input  logic [obtu_pkg::ANGLE_W-1:0]        pitch_angle_i,
  input  logic [obtu_pkg::CODE_W-1:0]         half_x_code_i,
  input  logic [obtu_pkg::CODE_W-1:0]         half_y_code_i,
  input  logic [obtu_pkg::CODE_W-1:0]         half_z_code_i,
  output logic                                done_o,
  output logic                                inside_res_o
);

  logic accept;
  obtu_pkg::rot_in_t s1_d, s1_q, s2_q;
  obtu_pkg::trig_t trig;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Offsets from the box centre, held one bit wider so nothing wraps.
  always_comb begin
    s1_d.valid = accept;
    s1_d.rx = $signed({point_x_i[obtu_pkg::COORD_W-1], point_x_i})
              - $signed({origin_x_i[obtu_pkg::COORD_W-1], origin_x_i});
    s1_d.ry = $signed({point_y_i[obtu_pkg::COORD_W-1], point_y_i})
              - $signed({origin_y_i[obtu_pkg::COORD_W-1], origin_y_i});
    s1_d.rz = $signed({point_z_i[obtu_pkg::COORD_W-1], point_z_i})
              - $signed({origin_z_i[obtu_pkg::COORD_W-1], origin_z_i});
    s1_d.hx = half_x_code_i;
    s1_d.hy = half_y_code_i;
    s1_d.hz = half_z_code_i;
  end

  // The two lookup stages: valid bits cleared at reset, payload waits beside
  // the table lookup.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
    end else begin
      s1_q <= s1_d;
      s2_q <= s1_q;
    end
  end

  obtu_sincos u_sincos (
    .clk_i   (clk_i),
    .yaw_i   (yaw_angle_i),
    .pitch_i (pitch_angle_i),
    .trig_o  (trig)
  );

  obtu_rotate u_rotate (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (s2_q),
    .trig_i   (trig),
    .done_o   (done_o),
    .inside_o (inside_res_o)
  );

endmodule

### sv/obtu_sine_rom.sv
// Quarter-wave sine table with a registered read port.
// Depends on obtu_pkg for the table contents and widths.
module obtu_sine_rom (
  input  logic                       clk_i,
  input  logic [obtu_pkg::IDX_W-1:0] addr_i,
  output obtu_pkg::sine_t            data_o
);

  obtu_pkg::sine_t data_q;

  // One read per cycle, data appears after the clock edge.
  always_ff @(posedge clk_i) begin
    data_q <= obtu_pkg::SINE_ROM[addr_i];
  end

  assign data_o = data_q;

endmodule

### sv/obtu_sincos.sv
// Two-stage sine and cosine lookup for the negated yaw and pitch angles.
// Depends on obtu_pkg and obtu_sine_rom.
module obtu_sincos (
  input  logic                         clk_i,
  input  logic [obtu_pkg::ANGLE_W-1:0] yaw_i,
  input  logic [obtu_pkg::ANGLE_W-1:0] pitch_i,
  output obtu_pkg::trig_t              trig_o
);

  localparam int RPROD_W = 14 + obtu_pkg::IDX_W;

  typedef struct packed {
    logic [obtu_pkg::IDX_W-1:0] addr;
    logic                       neg;
  } lookup_t;

  // Quadrant fold: table address and sign for one angle.
  function automatic lookup_t fold(input logic [obtu_pkg::ANGLE_W-1:0] a);
    lookup_t l;
    logic [RPROD_W-1:0] prod;
    logic [obtu_pkg::IDX_W-1:0] idx;
    prod = RPROD_W'(a[13:0]) * RPROD_W'(obtu_pkg::SINE_TABLE_ENTRIES);
    idx = obtu_pkg::IDX_W'(prod >> 14);
    l.addr = a[14] ? obtu_pkg::IDX_W'(obtu_pkg::SINE_TABLE_ENTRIES) - idx : idx;
    l.neg = a[15];
    return l;
  endfunction

  function automatic logic signed [obtu_pkg::TRIG_W-1:0] apply_sign(
    input obtu_pkg::sine_t d, input logic neg);
    logic signed [obtu_pkg::TRIG_W-1:0] v;
    v = $signed({1'b0, d});
    return neg ? -v : v;
  endfunction

  logic [obtu_pkg::ANGLE_W-1:0] yaw_neg, pitch_neg;
  lookup_t s_d, c_d, sp_d, cp_d;
  lookup_t s_q, c_q, sp_q, cp_q;
  logic [3:0] neg2_q;
  obtu_pkg::sine_t s_rd, c_rd, sp_rd, cp_rd;

  // Negate the angles and fold each into the first quadrant.
  always_comb begin
    yaw_neg = obtu_pkg::ANGLE_W'(0) - yaw_i;
    pitch_neg = obtu_pkg::ANGLE_W'(0) - pitch_i;
    s_d = fold(yaw_neg);
    c_d = fold(yaw_neg + obtu_pkg::ANGLE_W'(16384));
    sp_d = fold(pitch_neg);
    cp_d = fold(pitch_neg + obtu_pkg::ANGLE_W'(16384));
  end

  // Address register, then the sign flags follow the table read.
  always_ff @(posedge clk_i) begin
    s_q <= s_d;
    c_q <= c_d;
    sp_q <= sp_d;
    cp_q <= cp_d;
    neg2_q <= {s_q.neg, c_q.neg, sp_q.neg, cp_q.neg};
  end

  obtu_sine_rom u_rom_s  (.clk_i(clk_i), .addr_i(s_q.addr),  .data_o(s_rd));
  obtu_sine_rom u_rom_c  (.clk_i(clk_i), .addr_i(c_q.addr),  .data_o(c_rd));
  obtu_sine_rom u_rom_sp (.clk_i(clk_i), .addr_i(sp_q.addr), .data_o(sp_rd));
  obtu_sine_rom u_rom_cp (.clk_i(clk_i), .addr_i(cp_q.addr), .data_o(cp_rd));

  // Restore the sign of the lower half turn.
  always_comb begin
    trig_o.s = apply_sign(s_rd, neg2_q[3]);
    trig_o.c = apply_sign(c_rd, neg2_q[2]);
    trig_o.sp = apply_sign(sp_rd, neg2_q[1]);
    trig_o.cp = apply_sign(cp_rd, neg2_q[0]);
  end

endmodule

### sv/obtu_rotate.sv
// Rotation and limit compare pipeline: five register stages from trig to result.
// Depends on obtu_pkg for the payload structs and widths.
module obtu_rotate (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  obtu_pkg::rot_in_t in_i,
  input  obtu_pkg::trig_t   trig_i,
  output logic              done_o,
  output logic              inside_o
);

  localparam int LX_LIM_W = obtu_pkg::FWD_W + 1;

  typedef struct packed {
    logic [obtu_pkg::CODE_W-1:0] hx;
    logic [obtu_pkg::CODE_W-1:0] hy;
    logic [obtu_pkg::CODE_W-1:0] hz;
  } codes_t;

  // Valid bits of stages three to seven.
  logic [4:0] valid_q;

  // Stage three: first products.
  logic signed [obtu_pkg::PROD_W-1:0] xc3_q, zs3_q, xs3_q, zc3_q, yc3_q, ys3_q;
  codes_t codes3_q;
  // Stage four: local x and forward component.
  logic signed [obtu_pkg::FWD_W-1:0] lx4_d, fwd4_d, lx4_q, fwd4_q;
  logic signed [obtu_pkg::PROD_W-1:0] yc4_q, ys4_q;
  codes_t codes4_q;
  // Stage five: forward times pitch terms, x verdict.
  logic signed [obtu_pkg::WIDE_W-1:0] fsp5_q, fcp5_q;
  logic signed [obtu_pkg::PROD_W-1:0] yc5_q, ys5_q;
  logic signed [LX_LIM_W-1:0] limx;
  logic okx5_d, okx5_q;
  codes_t codes4_to5_q;
  // Pitch sine and cosine held until the forward component is ready.
  logic signed [obtu_pkg::TRIG_W-1:0] sp3_q, cp3_q, trig_i_sp_hold, trig_i_cp_hold;
  // Stage six: local y and z.
  logic signed [obtu_pkg::LOC_W-1:0] ly6_d, lz6_d, ly6_q, lz6_q;
  logic okx6_q;
  codes_t codes6_q;
  // Stage seven: output register.
  logic signed [obtu_pkg::LOC_W-1:0] limy, limz;
  logic inside_d, inside_q;

  // Valid bits follow the data; the receiver never stalls.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[3:0], in_i.valid};
    end
  end

  // Stage three products.
  always_ff @(posedge clk_i) begin
    xc3_q <= obtu_pkg::PROD_W'(in_i.rx * trig_i.c);
    zs3_q <= obtu_pkg::PROD_W'(in_i.rz * trig_i.s);
    xs3_q <= obtu_pkg::PROD_W'(in_i.rx * trig_i.s);
    zc3_q <= obtu_pkg::PROD_W'(in_i.rz * trig_i.c);
    yc3_q <= obtu_pkg::PROD_W'(in_i.ry * trig_i.cp);
    ys3_q <= obtu_pkg::PROD_W'(in_i.ry * trig_i.sp);
    codes3_q <= '{hx: in_i.hx, hy: in_i.hy, hz: in_i.hz};
  end

  // Stage four: yaw rotation sums.
  always_comb begin
    lx4_d = obtu_pkg::FWD_W'(xc3_q) - obtu_pkg::FWD_W'(zs3_q);
    fwd4_d = obtu_pkg::FWD_W'(xs3_q) + obtu_pkg::FWD_W'(zc3_q);
  end

  always_ff @(posedge clk_i) begin
    lx4_q <= lx4_d;
    fwd4_q <= fwd4_d;
    yc4_q <= yc3_q;
    ys4_q <= ys3_q;
    codes4_q <= codes3_q;
  end

  // Stage five: pitch products and the x limit check (limit is code * 2^25).
  always_comb begin
    limx = $signed(LX_LIM_W'(codes4_q.hx) << 25);
    okx5_d = (LX_LIM_W'(lx4_q) <= limx) && (LX_LIM_W'(lx4_q) >= -limx);
  end

  always_ff @(posedge clk_i) begin
    fsp5_q <= obtu_pkg::WIDE_W'(fwd4_q * trig_i_sp_hold);
    fcp5_q <= obtu_pkg::WIDE_W'(fwd4_q * trig_i_cp_hold);
    yc5_q <= yc4_q;
    ys5_q <= ys4_q;
    okx5_q <= okx5_d;
    codes4_to5_q <= codes4_q;
  end

  // Two-stage hold of the pitch terms.
  always_ff @(posedge clk_i) begin
    sp3_q <= trig_i.sp;
    cp3_q <= trig_i.cp;
    trig_i_sp_hold <= sp3_q;
    trig_i_cp_hold <= cp3_q;
  end

  // Stage six: pitch rotation sums.
  always_comb begin
    ly6_d = (obtu_pkg::LOC_W'(yc5_q) <<< 16) - obtu_pkg::LOC_W'(fsp5_q);
    lz6_d = (obtu_pkg::LOC_W'(ys5_q) <<< 16) + obtu_pkg::LOC_W'(fcp5_q);
  end

  always_ff @(posedge clk_i) begin
    ly6_q <= ly6_d;
    lz6_q <= lz6_d;
    okx6_q <= okx5_q;
    codes6_q <= codes4_to5_q;
  end

  // Stage seven: y and z limits are code * 2^41, inclusive.
  always_comb begin
    limy = $signed(obtu_pkg::LOC_W'(codes6_q.hy) << 41);
    limz = $signed(obtu_pkg::LOC_W'(codes6_q.hz) << 41);
    inside_d = okx6_q && (ly6_q <= limy) && (ly6_q >= -limy)
               && (lz6_q <= limz) && (lz6_q >= -limz);
  end

  always_ff @(posedge clk_i) begin
    inside_q <= inside_d;
  end

  assign done_o = valid_q[4];
  assign inside_o = inside_q;

endmodule

### sv/obtu_checker.sv
// Port-level checks of the oriented box point test unit, bound to the top level.
// Depends on oriented_box_point_test_unit_defines.svh for the assertion macros.
`include "oriented_box_point_test_unit_defines.svh"

module obtu_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic done_o
);

  // The block never pushes back on the sender.
  `OBTU_ASSERT_NEVER(a_never_busy, clk_i, rst_ni, busy_o)

  // Every result answers an earlier transfer made while out of reset.
  `OBTU_ASSERT_IMPLIES(a_done_has_query, clk_i, rst_ni, done_o, $past(start_i, 7) && $past(rst_ni, 7))

  // Every transfer with no reset since is answered by a result.
  `OBTU_ASSERT_IMPLIES(a_query_answered, clk_i, rst_ni, $past(start_i && !busy_o && rst_ni, 7) && $past(rst_ni, 6) && $past(rst_ni, 5) && $past(rst_ni, 4) && $past(rst_ni, 3) && $past(rst_ni, 2) && $past(rst_ni, 1), done_o)

endmodule

bind oriented_box_point_test_unit obtu_checker u_obtu_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .done_o  (done_o)
);

### dv/tb.sv
// Self-checking testbench for oriented_box_point_test_unit: queries with random gaps
// and a bit-exact inside/outside predictor with its own quarter-wave sine table.
// Depends on obtu_pkg for the port widths and the table size.
module tb;

  localparam int COORD_W = obtu_pkg::COORD_W;
  localparam int ANGLE_W = obtu_pkg::ANGLE_W;
  localparam int CODE_W = obtu_pkg::CODE_W;
  localparam int TBL_N = obtu_pkg::SINE_TABLE_ENTRIES;
  localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
  localparam int RANDOM_QUERIES = 1750;
  localparam int SETTLE_CYCLES = 12;
  localparam int ORIGIN_SPAN = 8388608 - 524288;

  // Quadrants of the 16-bit angle, from its top two bits.
  typedef enum logic [1:0] {
    QUAD_RISE,
    QUAD_FALL,
    QUAD_NEG_RISE,
    QUAD_NEG_FALL
  } quadrant_e;

  // One query as presented on the input ports.
  typedef struct {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
    logic [ANGLE_W-1:0]        yaw_angle;
    logic [ANGLE_W-1:0]        pitch_angle;
    logic [CODE_W-1:0]         half_x_code;
    logic [CODE_W-1:0]         half_y_code;
    logic [CODE_W-1:0]         half_z_code;
    bit                        hold_for_drain;
  } box_query_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      start_i = 1'b0;
  logic                      busy_o;
  logic signed [COORD_W-1:0] point_x_i = '0;
  logic signed [COORD_W-1:0] point_y_i = '0;
  logic signed [COORD_W-1:0] point_z_i = '0;
  logic signed [COORD_W-1:0] origin_x_i = '0;
  logic signed [COORD_W-1:0] origin_y_i = '0;
  logic signed [COORD_W-1:0] origin_z_i = '0;
  logic [ANGLE_W-1:0]        yaw_angle_i = '0;
  logic [ANGLE_W-1:0]        pitch_angle_i = '0;
  logic [CODE_W-1:0]         half_x_code_i = '0;
  logic [CODE_W-1:0]         half_y_code_i = '0;
  logic [CODE_W-1:0]         half_z_code_i = '0;
  logic                      done_o;
  logic                      inside_res_o;

  longint     quarter_sine [0:TBL_N];
  box_query_t pending_queries [$];
  bit         inside_expected [$];
  box_query_t on_offer;
  int         burst_left = 1;
  int         gap_left = 0;
  int         queries_sent = 0;
  int         results_seen = 0;
  int         inside_seen = 0;
  int         mismatches = 0;

  oriented_box_point_test_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .point_z_i     (point_z_i),
    .origin_x_i    (origin_x_i),
    .origin_y_i    (origin_y_i),
    .origin_z_i    (origin_z_i),
    .yaw_angle_i   (yaw_angle_i),
    .pitch_angle_i (pitch_angle_i),
    .half_x_code_i (half_x_code_i),
    .half_y_code_i (half_y_code_i),
    .half_z_code_i (half_z_code_i),
    .done_o        (done_o),
    .inside_res_o  (inside_res_o)
  );

  // Quarter-wave table: Taylor series in Q.30 with truncating steps, rounded to Q.16.
  function automatic void build_quarter_sine();
    longint unsigned t;
    longint unsigned term;
    longint acc;
    for (int i = 0; i <= TBL_N; i++) begin
      t = (longint'(i) * QUARTER_TURN_Q30) / longint'(TBL_N);
      term = t;
      acc = longint'(t);
      for (int k = 1; k <= 7; k++) begin
        term = (term * t) >> 30;
        term = ((term * t) >> 30) / longint'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) begin
          acc = acc - longint'(term);
        end else begin
          acc = acc + longint'(term);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      acc = (acc + 8192) / 16384;
      if (acc > 65536) begin
        acc = 65536;
      end
      quarter_sine[i] = acc;
    end
  endfunction

  // Sine of a 16-bit angle in Q.16, folded onto the quarter-wave table.
  function automatic longint table_sine(logic [ANGLE_W-1:0] a);
    longint idx;
    idx = (longint'(a[13:0]) * TBL_N) >>> 14;
    if (idx > TBL_N) begin
      idx = TBL_N;
    end
    case (quadrant_e'(a[15:14]))
      QUAD_RISE:     return quarter_sine[idx];
      QUAD_FALL:     return quarter_sine[TBL_N - idx];
      QUAD_NEG_RISE: return -quarter_sine[idx];
      default:       return -quarter_sine[TBL_N - idx];
    endcase
  endfunction

  function automatic longint magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Rotates the offset by the negated yaw, then the negated pitch, and compares each local
  // coordinate against its code times 2^25 (x) or 2^41 (y, z); every product is kept exact.
  function automatic bit predict_inside(box_query_t q);
    longint rx, ry, rz, c, s, cp, sp, lx, fwd, ly, lz;
    logic [ANGLE_W-1:0] yaw_neg;
    logic [ANGLE_W-1:0] pitch_neg;
    rx = longint'(q.point_x) - longint'(q.origin_x);
    ry = longint'(q.point_y) - longint'(q.origin_y);
    rz = longint'(q.point_z) - longint'(q.origin_z);
    yaw_neg = ~q.yaw_angle + 16'd1;
    pitch_neg = ~q.pitch_angle + 16'd1;
    s = table_sine(yaw_neg);
    c = table_sine(yaw_neg + 16'h4000);
    sp = table_sine(pitch_neg);
    cp = table_sine(pitch_neg + 16'h4000);
    lx = rx * c - rz * s;
    fwd = rx * s + rz * c;
    ly = ry * cp * 65536 - fwd * sp;
    lz = ry * sp * 65536 + fwd * cp;
    return magnitude(lx) <= (longint'(q.half_x_code) <<< 25)
        && magnitude(ly) <= (longint'(q.half_y_code) <<< 41)
        && magnitude(lz) <= (longint'(q.half_z_code) <<< 41);
  endfunction

  task automatic queue_query(input int px, input int py, input int pz,
                             input int ox, input int oy, input int oz,
                             input int yaw, input int pitch,
                             input int hx, input int hy, input int hz,
                             input bit hold);
    box_query_t q;
    q.point_x = COORD_W'(px);
    q.point_y = COORD_W'(py);
    q.point_z = COORD_W'(pz);
    q.origin_x = COORD_W'(ox);
    q.origin_y = COORD_W'(oy);
    q.origin_z = COORD_W'(oz);
    q.yaw_angle = ANGLE_W'(yaw);
    q.pitch_angle = ANGLE_W'(pitch);
    q.half_x_code = CODE_W'(hx);
    q.half_y_code = CODE_W'(hy);
    q.half_z_code = CODE_W'(hz);
    q.hold_for_drain = hold;
    pending_queries.push_back(q);
  endtask

  // Random query: mostly boxes near the point, some on quarter turns with offsets
  // right at a limit, and the rest fully random bit patterns.
  task automatic queue_random_query(input bit hold);
    int kind, ox, oy, oz, hx, hy, hz, yaw, pitch, span, pick;
    int off [3];
    kind = $urandom_range(0, 99);
    hx = $urandom_range(0, 255);
    hy = $urandom_range(0, 255);
    hz = $urandom_range(0, 255);
    ox = int'($urandom_range(0, 2 * ORIGIN_SPAN)) - ORIGIN_SPAN;
    oy = int'($urandom_range(0, 2 * ORIGIN_SPAN)) - ORIGIN_SPAN;
    oz = int'($urandom_range(0, 2 * ORIGIN_SPAN)) - ORIGIN_SPAN;
    if (kind < 20) begin
      queue_query($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, hx, hy, hz, hold);
    end else if (kind < 40) begin
      yaw = $urandom_range(0, 3) << 14;
      pitch = $urandom_range(0, 3) << 14;
      for (int k = 0; k < 3; k++) begin
        pick = $urandom_range(0, 2);
        off[k] = 512 * ((pick == 0) ? hx : (pick == 1) ? hy : hz)
                 + int'($urandom_range(0, 2)) - 1;
        if ($urandom_range(0, 4) == 0) begin
          off[k] = int'($urandom_range(0, 2)) - 1;
        end
        if ($urandom_range(0, 1) == 1) begin
          off[k] = -off[k];
        end
      end
      queue_query(ox + off[0], oy + off[1], oz + off[2], ox, oy, oz,
                  yaw, pitch, hx, hy, hz, hold);
    end else begin
      span = hx;
      if (hy < span) span = hy;
      if (hz < span) span = hz;
      span = (span * 512 * int'($urandom_range(1, 4))) / 3 + 256;
      for (int k = 0; k < 3; k++) begin
        off[k] = int'($urandom_range(0, 2 * span)) - span;
      end
      queue_query(ox + off[0], oy + off[1], oz + off[2], ox, oy, oz,
                  $urandom, $urandom, hx, hy, hz, hold);
    end
  endtask

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Stimulus, reset and end of run.
  initial begin
    int spin;
    build_quarter_sine();
    // Zero-size box: only a point on the centre passes.
    queue_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    queue_query(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    queue_query(1234567, -765432, 42, 1234567, -765432, 42, 12345, 54321, 0, 0, 0, 0);
    // Coordinates exactly on a limit count as inside; one step beyond does not.
    queue_query(130560, 0, 0, 0, 0, 0, 0, 0, 255, 255, 255, 0);
    queue_query(130561, 0, 0, 0, 0, 0, 0, 0, 255, 255, 255, 0);
    queue_query(-130560, 0, 0, 0, 0, 0, 0, 0, 255, 255, 255, 0);
    queue_query(0, 130560, 0, 0, 0, 0, 0, 0, 255, 255, 255, 0);
    queue_query(0, -130561, 0, 0, 0, 0, 0, 0, 255, 255, 255, 0);
    queue_query(0, 0, 130560, 0, 0, 0, 0, 0, 255, 255, 255, 0);
    queue_query(0, 0, 130561, 0, 0, 0, 0, 0, 255, 255, 255, 0);
    // Quarter turns move one axis onto another.
    queue_query(0, 0, 5120, 0, 0, 0, 16384, 0, 10, 255, 255, 0);
    queue_query(0, 0, 5121, 0, 0, 0, 16384, 0, 10, 255, 255, 0);
    queue_query(0, 3584, 0, 0, 0, 0, 0, 16384, 255, 255, 7, 0);
    queue_query(0, -3585, 0, 0, 0, 0, 0, 16384, 255, 255, 7, 0);
    queue_query(1, 1, 1, 0, 0, 0, 8192, 8192, 1, 1, 1, 0);
    // Extreme coordinates and angles: the widest differences must not wrap.
    queue_query(8388607, 8388607, 8388607, -8388608, -8388608, -8388608,
                65535, 65535, 255, 255, 255, 0);
    queue_query(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607,
                32768, 16384, 255, 255, 255, 0);
    queue_query(8388607, 8388607, 8388607, 8388607, 8388607, 8388607,
                49152, 32768, 0, 0, 0, 0);
    queue_query(-8388608, -8388608, -8388608, -8388608, -8388608, -8388608,
                16384, 49152, 255, 255, 255, 0);
    queue_query(-8388608, 8388607, -8388608, 8388607, -8388608, 8388607,
                0, 0, 255, 255, 255, 0);
    for (int n = 0; n < RANDOM_QUERIES; n++) begin
      queue_random_query(n == 0 || n == 700 || n == 1300);
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_queries.size() != 0 || start_i) @(negedge clk_i);
    spin = 0;
    while (inside_expected.size() != 0 && spin < 200) begin
      @(negedge clk_i);
      spin++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (inside_expected.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, inside_expected.size());
      mismatches += inside_expected.size();
    end
    $display("Checked %0d of %0d queries: %0d inside, %0d outside.",
             results_seen, queries_sent, inside_seen, results_seen - inside_seen);
    $display("Covered limit-equal, zero-size, quarter-turn and extreme-coordinate cases.");
    if (mismatches == 0) begin
      $display("oriented_box_point_test_unit verification clean");
    end else begin
      $display("oriented_box_point_test_unit verification failed");
    end
    $finish;
  end

  // Driver: offers queries in bursts with random gaps; a held query waits until
  // every outstanding result has been transferred.
  always @(posedge clk_i) begin
    logic offer;
    if (rst_ni) begin
      offer = start_i;
      if (start_i && !busy_o) begin
        inside_expected.push_back(predict_inside(on_offer));
        queries_sent++;
        offer = 1'b0;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 48);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
        end
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_queries.size() != 0 &&
                     !(pending_queries[0].hold_for_drain && inside_expected.size() != 0)) begin
          on_offer = pending_queries.pop_front();
          offer = 1'b1;
          point_x_i <= on_offer.point_x;
          point_y_i <= on_offer.point_y;
          point_z_i <= on_offer.point_z;
          origin_x_i <= on_offer.origin_x;
          origin_y_i <= on_offer.origin_y;
          origin_z_i <= on_offer.origin_z;
          yaw_angle_i <= on_offer.yaw_angle;
          pitch_angle_i <= on_offer.pitch_angle;
          half_x_code_i <= on_offer.half_x_code;
          half_y_code_i <= on_offer.half_y_code;
          half_z_code_i <= on_offer.half_z_code;
        end
      end
      start_i <= offer;
    end
  end

  // Monitor: every result transfer is checked against the oldest prediction.
  always @(posedge clk_i) begin
    bit want;
    if (rst_ni && done_o) begin
      if (inside_expected.size() == 0) begin
        $display("%0t: result with no query outstanding, expected none, actual inside=%0b",
                 $time, inside_res_o);
        mismatches++;
      end else begin
        want = inside_expected.pop_front();
        results_seen++;
        if (inside_res_o === 1'b1) begin
          inside_seen++;
        end
        if (inside_res_o !== want) begin
          $display("%0t: inside mismatch, expected %0b, actual %0b",
                   $time, want, inside_res_o);
          mismatches++;
        end
      end
    end
  end

  // Watchdog for a hung pipeline or a stuck handshake.
  initial begin
    #2000000;
    $display("oriented_box_point_test_unit verification failed");
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/obtu_pkg.sv
sv/obtu_sine_rom.sv
sv/obtu_sincos.sv
sv/obtu_rotate.sv
sv/oriented_box_point_test_unit.sv
sv/obtu_checker.sv
dv/tb.sv
